[sv/dsv_pkg.sv]
// shared types, constants and error codes of the date string validator
package dsv_pkg;

  localparam int YEAR_W      = 14;
  localparam int FIELD_W     = 7;
  localparam int MONTH_CFG_W = 4;
  localparam int ERR_W       = 3;
  localparam int DATE_W      = 27;
  localparam int CHAR_W      = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int QUOT_W      = 8;
  localparam int REM_W       = 7;

  localparam int DSV_QUEUE_DEPTH = 2;

  localparam logic [CHAR_W-1:0] CH_ZERO = 8'd48;
  localparam logic [CHAR_W-1:0] CH_NINE = 8'd57;
  localparam logic [CHAR_W-1:0] CH_DASH = 8'd45;

  localparam logic [YEAR_W-1:0]  MIN_YEAR     = 14'd2000;
  localparam logic [YEAR_W-1:0]  MAX_YEAR_FIT = 14'd9999;
  localparam logic [YEAR_W-1:0]  YEAR_SAT     = 14'd16383;
  localparam logic [FIELD_W-1:0] FIELD_SAT    = 7'd127;
  localparam logic [FIELD_W-1:0] MONTH_MAX    = 7'd12;

  localparam logic [YEAR_W-1:0]      CUR_YEAR_RST  = 14'd2000;
  localparam logic [MONTH_CFG_W-1:0] CUR_MONTH_RST = 4'd1;

  // y / 100 as (y * 5243) >> 19, exact for every 14-bit y
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int          DIV100_SHIFT = 19;
  localparam logic [YEAR_W-1:0] CENT   = 14'd100;
  localparam logic [DATE_W-1:0] TEN_K  = 27'd10000;
  localparam logic [DATE_W-1:0] MIN_PACKED = 27'd20000101;

  localparam logic [CFG_IDX_W-1:0] CFG_YEAR  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MONTH = 1'd1;

  localparam logic [ERR_W-1:0] ERR_OK     = 3'd0;
  localparam logic [ERR_W-1:0] ERR_FORMAT = 3'd1;
  localparam logic [ERR_W-1:0] ERR_CHAR   = 3'd2;
  localparam logic [ERR_W-1:0] ERR_YEAR   = 3'd3;
  localparam logic [ERR_W-1:0] ERR_MONTH  = 3'd4;
  localparam logic [ERR_W-1:0] ERR_DAY    = 3'd5;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [FIELD_W-1:0] month;
    logic [FIELD_W-1:0] day;
    logic [ERR_W-1:0]   err;
  } dsv_rec_t;

endpackage

[sv/dsv_fifo.sv]
// small register queue between the character front end and the date checker
module dsv_fifo #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == FULL_CNT);
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue read while empty");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("queue count beyond depth");

endmodule

[sv/dsv_front.sv]
// character front end: field accumulators, format and character checks
module dsv_front
  import dsv_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAR_W-1:0] in_char_code,
  input  logic              in_is_last,
  input  logic              q_full,
  output logic              push,
  output dsv_rec_t          push_rec
);

  logic [YEAR_W-1:0]  year_r, year_nxt;
  logic [FIELD_W-1:0] month_r, month_nxt;
  logic [FIELD_W-1:0] day_r, day_nxt;
  logic [1:0]         dash_r, dash_nxt;
  logic               prev_dash_r;
  logic               first_r;
  logic [ERR_W-1:0]   ferr_r, ferr_nxt;

  logic               is_dash;
  logic               is_digit;
  logic [3:0]         digit;
  logic [YEAR_W+3:0]  year_calc;
  logic [FIELD_W+3:0] month_calc;
  logic [FIELD_W+3:0] day_calc;
  logic               take;
  logic [ERR_W-1:0]   end_err;

  assign in_stall = q_full;
  assign take     = in_valid && !in_stall;
  assign push     = take && in_is_last;

  always_comb begin
    is_dash  = (in_char_code == CH_DASH);
    is_digit = (in_char_code >= CH_ZERO) && (in_char_code <= CH_NINE);
    digit    = in_char_code[3:0];

    year_calc  = (YEAR_W+4)'({year_r, 3'b000}) + (YEAR_W+4)'({year_r, 1'b0})
               + (YEAR_W+4)'(digit);
    month_calc = (FIELD_W+4)'({month_r, 3'b000}) + (FIELD_W+4)'({month_r, 1'b0})
               + (FIELD_W+4)'(digit);
    day_calc   = (FIELD_W+4)'({day_r, 3'b000}) + (FIELD_W+4)'({day_r, 1'b0})
               + (FIELD_W+4)'(digit);

    year_nxt  = year_r;
    month_nxt = month_r;
    day_nxt   = day_r;
    if (is_digit) begin
      if (dash_r == 2'd0) begin
        year_nxt = (year_calc > (YEAR_W+4)'(YEAR_SAT)) ? YEAR_SAT : year_calc[YEAR_W-1:0];
      end else if (dash_r == 2'd1) begin
        month_nxt = (month_calc > (FIELD_W+4)'(FIELD_SAT)) ? FIELD_SAT
                                                           : month_calc[FIELD_W-1:0];
      end else begin
        day_nxt = (day_calc > (FIELD_W+4)'(FIELD_SAT)) ? FIELD_SAT : day_calc[FIELD_W-1:0];
      end
    end

    dash_nxt = (is_dash && dash_r != 2'd3) ? dash_r + 2'd1 : dash_r;

    ferr_nxt = ferr_r;
    if (ferr_r == ERR_OK) begin
      if (first_r && is_dash) begin
        ferr_nxt = ERR_FORMAT;
      end else if (!is_digit && !is_dash) begin
        ferr_nxt = ERR_CHAR;
      end else if (is_dash && prev_dash_r) begin
        ferr_nxt = ERR_FORMAT;
      end
    end

    end_err = ferr_nxt;
    if (ferr_nxt == ERR_OK && (dash_nxt != 2'd2 || is_dash)) begin
      end_err = ERR_FORMAT;
    end

    push_rec.year  = year_nxt;
    push_rec.month = month_nxt;
    push_rec.day   = day_nxt;
    push_rec.err   = end_err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      year_r      <= '0;
      month_r     <= '0;
      day_r       <= '0;
      dash_r      <= '0;
      prev_dash_r <= 1'b0;
      first_r     <= 1'b1;
      ferr_r      <= ERR_OK;
    end else if (take) begin
      if (in_is_last) begin
        year_r      <= '0;
        month_r     <= '0;
        day_r       <= '0;
        dash_r      <= '0;
        prev_dash_r <= 1'b0;
        first_r     <= 1'b1;
        ferr_r      <= ERR_OK;
      end else begin
        year_r      <= year_nxt;
        month_r     <= month_nxt;
        day_r       <= day_nxt;
        dash_r      <= dash_nxt;
        prev_dash_r <= is_dash;
        first_r     <= 1'b0;
        ferr_r      <= ferr_nxt;
      end
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (first_r && ferr_r == ERR_OK && dash_r == 2'd0))
    else $error("string state not cleared after final character");

  a_first_only_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !in_is_last) |=> !first_r)
    else $error("first character mark kept after a character");

endmodule

[sv/dsv_back.sv]
// date checker: year, month and day range checks, leap rule and date packing
module dsv_back
  import dsv_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [YEAR_W-1:0]      cur_year,
  input  logic [MONTH_CFG_W-1:0] cur_month,
  input  logic                   q_empty,
  input  dsv_rec_t               q_rec,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [ERR_W-1:0]       out_error_code,
  output logic [DATE_W-1:0]      out_packed_date
);

  // stage 1 registers
  logic               s1_v_r;
  logic [ERR_W-1:0]   s1_err_r;
  logic [YEAR_W-1:0]  s1_year_r;
  logic [FIELD_W-1:0] s1_month_r;
  logic [FIELD_W-1:0] s1_day_r;
  logic [QUOT_W-1:0]  s1_quot_r;
  logic [DATE_W-1:0]  s1_ybase_r;

  // output registers
  logic               out_valid_r;
  logic [ERR_W-1:0]   out_err_r;
  logic [DATE_W-1:0]  out_date_r;

  logic               out_rdy;
  logic               s1_rdy;

  logic [YEAR_W-1:0]  ybound;
  logic [ERR_W-1:0]   s1_err_nxt;
  logic [DATE_W-1:0]  div_prod;
  logic [QUOT_W-1:0]  quot_nxt;
  logic [DATE_W-1:0]  ybase_nxt;

  logic [YEAR_W-1:0]  rem_full;
  logic [REM_W-1:0]   rem;
  logic               leap;
  logic [4:0]         mdays;
  logic [ERR_W-1:0]   out_err_nxt;
  logic [DATE_W-1:0]  out_date_nxt;

  assign out_rdy = !out_valid_r || !out_stall;
  assign s1_rdy  = !s1_v_r || out_rdy;
  assign pop     = !q_empty && s1_rdy;

  always_comb begin
    ybound = (cur_year > MAX_YEAR_FIT) ? MAX_YEAR_FIT : cur_year;

    s1_err_nxt = q_rec.err;
    if (s1_err_nxt == ERR_OK && (q_rec.year < MIN_YEAR || q_rec.year > ybound)) begin
      s1_err_nxt = ERR_YEAR;
    end
    if (s1_err_nxt == ERR_OK &&
        (q_rec.month == '0 || q_rec.month > MONTH_MAX ||
         (q_rec.year == cur_year && q_rec.month > FIELD_W'(cur_month)))) begin
      s1_err_nxt = ERR_MONTH;
    end

    div_prod  = DATE_W'(q_rec.year) * DATE_W'(DIV100_MUL);
    quot_nxt  = QUOT_W'(div_prod >> DIV100_SHIFT);
    ybase_nxt = DATE_W'(q_rec.year) * TEN_K;
  end

  always_comb begin
    rem_full = s1_year_r - (YEAR_W'(s1_quot_r) * CENT);
    rem      = rem_full[REM_W-1:0];
    leap     = (rem != '0) ? (s1_year_r[1:0] == 2'b00) : (s1_quot_r[1:0] == 2'b00);

    unique case (s1_month_r) inside
      7'd4, 7'd6, 7'd9, 7'd11: mdays = 5'd30;
      7'd2:                    mdays = leap ? 5'd29 : 5'd28;
      default:                 mdays = 5'd31;
    endcase

    out_err_nxt = s1_err_r;
    if (out_err_nxt == ERR_OK && (s1_day_r == '0 || s1_day_r > FIELD_W'(mdays))) begin
      out_err_nxt = ERR_DAY;
    end

    out_date_nxt = '0;
    if (out_err_nxt == ERR_OK) begin
      out_date_nxt = s1_ybase_r + DATE_W'(YEAR_W'(s1_month_r) * CENT) + DATE_W'(s1_day_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_v_r <= pop;
      end
      if (out_rdy) begin
        out_valid_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_err_r   <= s1_err_nxt;
      s1_year_r  <= q_rec.year;
      s1_month_r <= q_rec.month;
      s1_day_r   <= q_rec.day;
      s1_quot_r  <= quot_nxt;
      s1_ybase_r <= ybase_nxt;
    end
    if (out_rdy && s1_v_r) begin
      out_err_r  <= out_err_nxt;
      out_date_r <= out_date_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_error_code  = out_err_r;
  assign out_packed_date = out_date_r;

  a_err_zero_date: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r != ERR_OK) |-> (out_date_r == '0))
    else $error("packed date not zero on an error result");

  a_ok_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r == ERR_OK) |-> (out_date_r >= MIN_PACKED))
    else $error("accepted date below the lowest valid date");

  a_pop_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (!s1_v_r || !out_valid_r || !out_stall))
    else $error("checker stage loaded while full and blocked");

endmodule

[sv/date_string_validator.sv]
// top level of the date string validator: configuration registers and block wiring
//
//  channel | direction | ports                                     | handshake
//  in      | input     | in_char_code, in_is_last                  | in_valid / in_stall
//  out     | output    | out_error_code, out_packed_date           | out_valid / out_stall
//  cfg     | input     | cfg_index, cfg_data                       | cfg_valid / cfg_ready
//
//  one character per cycle while in_stall is low; the front accumulators update as each character is taken
//  the result of a string passes the queue, the checker stage and the output registers to out_valid
//  a queue of QUEUE_DEPTH strings lets the front run on while the output is stalled
//  in_stall rises only when that queue is full; cfg_ready is always high
//  synchronous reset clears all string state and loads year 2000, month 1
module date_string_validator
  import dsv_pkg::*;
#(
  parameter int QUEUE_DEPTH = DSV_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CHAR_W-1:0]    in_char_code,
  input  logic                 in_is_last,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ERR_W-1:0]     out_error_code,
  output logic [DATE_W-1:0]    out_packed_date,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [YEAR_W-1:0]    cfg_data
);

  localparam int REC_W = $bits(dsv_rec_t);

  logic [YEAR_W-1:0]      cur_year_r;
  logic [MONTH_CFG_W-1:0] cur_month_r;

  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  dsv_rec_t         push_rec;
  dsv_rec_t         head_rec;
  logic [REC_W-1:0] head_bits;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_year_r  <= CUR_YEAR_RST;
      cur_month_r <= CUR_MONTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_YEAR:  cur_year_r  <= cfg_data;
        CFG_MONTH: cur_month_r <= cfg_data[MONTH_CFG_W-1:0];
        default:   ;
      endcase
    end
  end

  dsv_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_code (in_char_code),
    .in_is_last   (in_is_last),
    .q_full       (q_full),
    .push         (q_push),
    .push_rec     (push_rec)
  );

  dsv_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (REC_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_rec),
    .pop       (q_pop),
    .pop_data  (head_bits),
    .full      (q_full),
    .empty     (q_empty)
  );

  assign head_rec = head_bits;

  dsv_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cur_year        (cur_year_r),
    .cur_month       (cur_month_r),
    .q_empty         (q_empty),
    .q_rec           (head_rec),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_error_code  (out_error_code),
    .out_packed_date (out_packed_date)
  );

endmodule

[tb/testbench.sv]
// self-checking testbench for the date string validator with scoreboard, drivers and stimulus
module testbench;
  import dsv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_CHARS    = 205;
  localparam int LONG_HOLD      = 300;

  typedef struct packed {
    logic [ERR_W-1:0]  err;
    logic [DATE_W-1:0] date;
  } date_result_t;

  class date_result_board;
    logic [YEAR_W-1:0]      cur_year;
    logic [MONTH_CFG_W-1:0] cur_month;
    int                     year_acc;
    int                     month_acc;
    int                     day_acc;
    int                     dashes;
    bit                     prev_dash;
    bit                     first_char;
    logic [ERR_W-1:0]       first_err;
    date_result_t           pending_dates[$];
    int                     mismatches;

    function new();
      cur_year   = CUR_YEAR_RST;
      cur_month  = CUR_MONTH_RST;
      mismatches = 0;
      clear_string();
    endfunction

    function void clear_string();
      year_acc   = 0;
      month_acc  = 0;
      day_acc    = 0;
      dashes     = 0;
      prev_dash  = 1'b0;
      first_char = 1'b1;
      first_err  = ERR_OK;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [YEAR_W-1:0] data);
      if (idx == CFG_YEAR) begin
        cur_year = data;
      end else if (idx == CFG_MONTH) begin
        cur_month = data[MONTH_CFG_W-1:0];
      end
    endfunction

    function int month_length(int y, int m);
      bit leap;
      leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
      if (m == 2) return leap ? 29 : 28;
      return 31;
    endfunction

    // advances the string state by one character; the final one queues a result
    function void note_char(logic [CHAR_W-1:0] c, logic last);
      bit               dash;
      bit               digit;
      int               dig;
      int               ybound;
      logic [ERR_W-1:0] err;
      date_result_t     due;
      dash  = (c == CH_DASH);
      digit = (c >= CH_ZERO) && (c <= CH_NINE);
      if (first_err == ERR_OK) begin
        if (first_char && dash) first_err = ERR_FORMAT;
        else if (!digit && !dash) first_err = ERR_CHAR;
        else if (dash && prev_dash) first_err = ERR_FORMAT;
      end
      if (digit) begin
        dig = int'(c) - int'(CH_ZERO);
        if (dashes == 0) begin
          year_acc = year_acc * 10 + dig;
          if (year_acc > YEAR_SAT) year_acc = YEAR_SAT;
        end else if (dashes == 1) begin
          month_acc = month_acc * 10 + dig;
          if (month_acc > FIELD_SAT) month_acc = FIELD_SAT;
        end else begin
          day_acc = day_acc * 10 + dig;
          if (day_acc > FIELD_SAT) day_acc = FIELD_SAT;
        end
      end
      if (dash && dashes < 3) dashes++;
      prev_dash  = dash;
      first_char = 1'b0;
      if (!last) return;

      err = first_err;
      if (err == ERR_OK && (dashes != 2 || dash)) err = ERR_FORMAT;
      ybound = (cur_year > MAX_YEAR_FIT) ? MAX_YEAR_FIT : cur_year;
      if (err == ERR_OK && (year_acc < MIN_YEAR || year_acc > ybound)) err = ERR_YEAR;
      if (err == ERR_OK && (month_acc < 1 || month_acc > MONTH_MAX ||
                            (year_acc == cur_year && month_acc > cur_month)))
        err = ERR_MONTH;
      if (err == ERR_OK && (day_acc == 0 || day_acc > month_length(year_acc, month_acc)))
        err = ERR_DAY;
      due.err  = err;
      due.date = (err == ERR_OK) ? DATE_W'(year_acc * 10000 + month_acc * 100 + day_acc)
                                 : '0;
      pending_dates.push_back(due);
      clear_string();
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(logic [ERR_W-1:0] err, logic [DATE_W-1:0] date);
      date_result_t due;
      if (pending_dates.size() == 0) begin
        report($sformatf("result with nothing pending, error %0d date %0d", err, date));
        return;
      end
      due = pending_dates.pop_front();
      if (err !== due.err)
        report($sformatf("error code %0d, predicted %0d", err, due.err));
      if (date !== due.date)
        report($sformatf("packed date %0d, predicted %0d", date, due.date));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [CHAR_W-1:0]    in_char_code = '0;
  logic                 in_is_last = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [ERR_W-1:0]     out_error_code;
  logic [DATE_W-1:0]    out_packed_date;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [YEAR_W-1:0]    cfg_data = '0;

  date_result_board sb = new();
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  date_string_validator u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_code    (in_char_code),
    .in_is_last      (in_is_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_error_code  (out_error_code),
    .out_packed_date (out_packed_date),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_char(in_char_code, in_is_last);
      if (out_valid && !out_stall) sb.check_result(out_error_code, out_packed_date);
    end
  end

  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic void add_text(ref byte unsigned s[$], input string t);
    for (int i = 0; i < t.len(); i++) s.push_back(t[i]);
  endfunction

  function automatic void add_number(ref byte unsigned s[$], input int n);
    string t;
    t = $sformatf("%0d", n);
    if ($urandom_range(9) == 0) t = {"0", t};
    if ($urandom_range(19) == 0) t = {"00", t};
    add_text(s, t);
  endfunction

  // mostly well-formed dates around the configured bounds, the rest broken or noise
  function automatic void build_string(ref byte unsigned s[$]);
    int y;
    int m;
    int d;
    int pick;
    int r;
    int leap_years[10];
    leap_years = '{1996, 2000, 2004, 2023, 2024, 2100, 2200, 2400, 9996, 9999};
    s.delete();
    pick = $urandom_range(99);
    if (pick < 30) y = sb.cur_year;
    else if (pick < 55) y = $urandom_range(2100, 2000);
    else if (pick < 70) y = leap_years[$urandom_range(9)];
    else if (pick < 88) y = $urandom_range(9999, 1990);
    else y = $urandom_range(16383);
    m = ($urandom_range(99) < 80) ? $urandom_range(12, 1) : $urandom_range(20);
    if (pick >= 55 && pick < 70 && $urandom_range(1) == 1) m = 2;
    pick = $urandom_range(99);
    if (pick < 60) d = $urandom_range(28, 1);
    else if (pick < 85) d = $urandom_range(31, 28);
    else d = $urandom_range(40);
    add_number(s, y);
    add_text(s, "-");
    add_number(s, m);
    add_text(s, "-");
    add_number(s, d);

    pick = $urandom_range(99);
    if (pick < 82) return;
    case ((pick - 82) / 2)
      0: s[$urandom_range(s.size() - 1)] = byte'($urandom_range(255));
      1: s.push_front(CH_DASH);
      2: begin
        add_text(s, "-");
        add_number(s, $urandom_range(99));
      end
      3: s = s[0:$urandom_range(s.size() - 1)];
      4: s.insert($urandom_range(s.size() - 1), CH_DASH);
      5: begin
        // oversized fields that saturate
        repeat ($urandom_range(6, 2)) s.push_front(CHAR_W'(CH_ZERO + $urandom_range(9, 1)));
        if ($urandom_range(1) == 1)
          repeat ($urandom_range(4, 2)) s.push_back(CHAR_W'(CH_ZERO + $urandom_range(9)));
      end
      default: begin
        s.delete();
        repeat ($urandom_range(10, 1)) begin
          r = $urandom_range(99);
          if (r < 50) s.push_back(byte'($urandom_range(255)));
          else if (r < 80) s.push_back(CHAR_W'(CH_ZERO + $urandom_range(9)));
          else s.push_back(CH_DASH);
        end
      end
    endcase
  endfunction

  task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
    int gap;
    gap = 0;
    while ($urandom_range(99) < snd_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= c;
    in_is_last   <= last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_string(input byte unsigned s[$]);
    foreach (s[i]) send_char(s[i], i == s.size() - 1);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_dates.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [YEAR_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, data);
    @(negedge clk);
  endtask

  initial begin
    string             directed_texts[$];
    byte unsigned      text[$];
    int                phase_years[6];
    int                phase_months[6];
    int                yr;
    int                mo;
    int                sent;
    logic [YEAR_W-1:0] month_word;
    directed_texts = '{"2000-1-1", "1--", "9-9-", "-", "2:", "0/"};
    // the fifth setting is drawn at random
    phase_years  = '{2024, 9999, 16383, 2000, 0, 2100};
    phase_months = '{2, 12, 15, 0, 0, 13};
    snd_idle_pct = 23;
    rcv_idle_pct = 53;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_texts[i]) begin
      text.delete();
      add_text(text, directed_texts[i]);
      send_string(text);
    end
    text = {8'hff};
    send_string(text);
    text = {8'h00};
    send_string(text);

    for (int phase = 0; phase < 6; phase++) begin
      settle();
      yr = (phase == 4) ? $urandom_range(16383) : phase_years[phase];
      mo = (phase == 4) ? $urandom_range(15) : phase_months[phase];
      month_word = YEAR_W'($urandom_range(16383));
      month_word[MONTH_CFG_W-1:0] = MONTH_CFG_W'(mo);
      write_register(CFG_YEAR, YEAR_W'(yr));
      write_register(CFG_MONTH, month_word);
      cfg_valid <= 1'b0;
      snd_idle_pct = (phase < 2) ? 23 : (phase < 4) ? 53 : 0;
      rcv_idle_pct = (phase < 2) ? 53 : (phase < 4) ? 23 : 0;
      // output held off while strings keep coming, so the queue fills
      if (phase == 1) hold_req = LONG_HOLD;
      sent = 0;
      while (sent < PHASE_CHARS) begin
        build_string(text);
        send_string(text);
        sent += text.size();
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
